>>> rtl/hsb_to_rgb_converter_macros.svh
// assertion macros for the hsb to rgb converter
// used by the rtl modules that carry checks; needs clk and rst_n in scope
`ifndef HSB_TO_RGB_CONVERTER_MACROS_SVH
`define HSB_TO_RGB_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define HSB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsb_to_rgb_converter: check failed");
`define HSB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hsb_to_rgb_converter: check failed");
`else
`define HSB_ASSERT(lbl, prop)
`define HSB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/hsb2rgb_pkg.sv
// shared constants, types and stage payloads of the hsb to rgb converter
// no dependencies
package hsb2rgb_pkg;

    localparam int MAX_BRIGHT = 100;
    localparam int MAX_COLOR  = 4095;

    localparam int HUE_W = 9;
    localparam int SAT_W = 7;
    localparam int BRI_W = 7;
    localparam int CH_W  = 12;
    localparam int N_CH  = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int HUE_LIMIT = 360;
    localparam int SAT_LIMIT = 100;
    localparam int SPAN      = 120;
    localparam int BLEND_DEN = 12000;
    localparam int OUT_MAX   = 4095;
    localparam int OUT_CAP   = (MAX_COLOR < OUT_MAX) ? MAX_COLOR : OUT_MAX;

    localparam int BRI_MAX    = (1 << BRI_W) - 1;
    localparam int BRIGHT_CAP = (MAX_BRIGHT < BRI_MAX) ? MAX_BRIGHT : BRI_MAX;

    localparam int T_W   = $clog2(SPAN + 1);
    localparam int M_W   = $clog2(BLEND_DEN + 1);
    localparam int BM_W  = $clog2(BRIGHT_CAP * MAX_COLOR + 1);
    localparam int NUM_W = BM_W + M_W;

    // divide by a constant through a rounded-up reciprocal, exact for NUM_W-bit values
    localparam int DEN   = MAX_BRIGHT * BLEND_DEN;
    localparam int DEN_W = $clog2(DEN);
    localparam int SHIFT = NUM_W + DEN_W;
    localparam int RCP_W = NUM_W + 1;
    localparam logic [127:0] RCP_WIDE =
        ((128'd1 << SHIFT) + 128'(DEN) - 128'd1) / 128'(DEN);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_WIDE);

    localparam int Q_W   = $clog2(MAX_COLOR + 1);
    localparam int SUM_W = SHIFT + Q_W;

    localparam int NLO_W = NUM_W / 2;
    localparam int NHI_W = NUM_W - NLO_W;
    localparam int RLO_W = RCP_W / 2;
    localparam int RHI_W = RCP_W - RLO_W;
    localparam logic [RLO_W-1:0] RCP_LO = RCP[RLO_W-1:0];
    localparam logic [RHI_W-1:0] RCP_HI = RCP[RCP_W-1:RLO_W];

    localparam int LL_W = NLO_W + RLO_W;
    localparam int LH_W = NLO_W + RHI_W;
    localparam int HL_W = NHI_W + RLO_W;
    localparam int HH_W = NHI_W + RHI_W;

    typedef enum logic [1:0] {
        SEC_RG,
        SEC_GB,
        SEC_BR
    } sector_t;

    typedef struct packed {
        logic [T_W-1:0]   t;
        logic [T_W-1:0]   tc;
        logic [SAT_W-1:0] sat;
        logic [BRI_W-1:0] bright;
        sector_t          sector;
    } sect_t;

    typedef struct packed {
        logic [N_CH-1:0][M_W-1:0] m;
        logic [BM_W-1:0]          bm;
    } wgt_t;

    typedef logic [N_CH-1:0][CH_W-1:0] rgb_t;

endpackage

>>> rtl/hsb2rgb_sector.sv
// first pipeline stage: input clamping, hue sector and offset within the sector
// depends on hsb2rgb_pkg and the assertion macro header
`include "hsb_to_rgb_converter_macros.svh"

module hsb2rgb_sector
    import hsb2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [HUE_W-1:0] hue,
    input  logic [SAT_W-1:0] saturation,
    input  logic [BRI_W-1:0] brightness,
    output logic             out_valid,
    input  logic             out_ready,
    output sect_t            out_data
);

    logic             valid_reg;
    sect_t            data_reg;
    sect_t            data_next;
    logic [HUE_W-1:0] hue_c;
    logic [HUE_W-1:0] base;

    always_comb
    begin
        hue_c = (hue > HUE_W'(HUE_LIMIT)) ? HUE_W'(HUE_LIMIT) : hue;
        data_next.sat = (saturation > SAT_W'(SAT_LIMIT)) ? SAT_W'(SAT_LIMIT) : saturation;
        data_next.bright = (brightness > BRI_W'(BRIGHT_CAP)) ? BRI_W'(BRIGHT_CAP)
                                                              : brightness;
        priority if (hue_c < HUE_W'(SPAN))
        begin
            data_next.sector = SEC_RG;
            base = '0;
        end
        else if (hue_c < HUE_W'(2 * SPAN))
        begin
            data_next.sector = SEC_GB;
            base = HUE_W'(SPAN);
        end
        else
        begin
            // hue 360 stays in the last sector
            data_next.sector = SEC_BR;
            base = HUE_W'(2 * SPAN);
        end
        data_next.t  = T_W'(hue_c - base);
        data_next.tc = T_W'(SPAN) - data_next.t;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    `HSB_ASSERT(a_offset_span, valid_reg |-> (8'(data_reg.t) + 8'(data_reg.tc) == 8'(SPAN)))

endmodule

>>> rtl/hsb2rgb_blend.sv
// second pipeline stage: blend weights per channel and the brightness product
// depends on hsb2rgb_pkg and the assertion macro header
`include "hsb_to_rgb_converter_macros.svh"

module hsb2rgb_blend
    import hsb2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  sect_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output wgt_t  out_data
);

    logic           valid_reg;
    wgt_t           data_reg;
    wgt_t           data_next;
    logic [M_W-1:0] m_lead;
    logic [M_W-1:0] m_trail;
    logic [M_W-1:0] m_third;

    always_comb
    begin
        m_lead  = M_W'(BLEND_DEN) - M_W'(in_data.t) * M_W'(in_data.sat);
        m_trail = M_W'(BLEND_DEN) - M_W'(in_data.tc) * M_W'(in_data.sat);
        m_third = M_W'(BLEND_DEN) - M_W'(SPAN) * M_W'(in_data.sat);
        data_next.bm = BM_W'(in_data.bright) * BM_W'(MAX_COLOR);
        unique case (in_data.sector)
            SEC_GB:
            begin
                data_next.m[CH_RED]   = m_third;
                data_next.m[CH_GREEN] = m_lead;
                data_next.m[CH_BLUE]  = m_trail;
            end
            SEC_BR:
            begin
                data_next.m[CH_RED]   = m_trail;
                data_next.m[CH_GREEN] = m_third;
                data_next.m[CH_BLUE]  = m_lead;
            end
            default:
            begin
                data_next.m[CH_RED]   = m_lead;
                data_next.m[CH_GREEN] = m_trail;
                data_next.m[CH_BLUE]  = m_third;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    // the two sector weights together give one full weight plus the third one
    `HSB_ASSERT(a_weight_sum, valid_reg |-> ((17'(data_reg.m[0]) + 17'(data_reg.m[1]) + 17'(data_reg.m[2]) == 17'(BLEND_DEN) + (17'(data_reg.m[0]) << 1)) || (17'(data_reg.m[0]) + 17'(data_reg.m[1]) + 17'(data_reg.m[2]) == 17'(BLEND_DEN) + (17'(data_reg.m[1]) << 1)) || (17'(data_reg.m[0]) + 17'(data_reg.m[1]) + 17'(data_reg.m[2]) == 17'(BLEND_DEN) + (17'(data_reg.m[2]) << 1))))

endmodule

>>> rtl/hsb2rgb_cdiv.sv
// stages three to five: numerator product, reciprocal partial products,
// final sum with shift and saturation into the output register; needs hsb2rgb_pkg
`include "hsb_to_rgb_converter_macros.svh"

module hsb2rgb_cdiv
    import hsb2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  wgt_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rgb_t out_data
);

    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic rdy3;
    logic rdy4;
    logic rdy5;

    logic [N_CH-1:0][NUM_W-1:0] num_reg;
    logic [N_CH-1:0][NUM_W-1:0] num_next;
    logic [N_CH-1:0][LL_W-1:0]  ll_reg;
    logic [N_CH-1:0][LL_W-1:0]  ll_next;
    logic [N_CH-1:0][LH_W-1:0]  lh_reg;
    logic [N_CH-1:0][LH_W-1:0]  lh_next;
    logic [N_CH-1:0][HL_W-1:0]  hl_reg;
    logic [N_CH-1:0][HL_W-1:0]  hl_next;
    logic [N_CH-1:0][HH_W-1:0]  hh_reg;
    logic [N_CH-1:0][HH_W-1:0]  hh_next;
    logic [N_CH-1:0][SUM_W-1:0] sum;
    logic [N_CH-1:0][Q_W-1:0]   quo;
    rgb_t                       rgb_reg;
    rgb_t                       rgb_next;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    always_comb
    begin
        for (int c = 0; c < N_CH; c++)
        begin
            num_next[c] = NUM_W'(in_data.bm) * NUM_W'(in_data.m[c]);

            ll_next[c] = LL_W'(num_reg[c][NLO_W-1:0]) * LL_W'(RCP_LO);
            lh_next[c] = LH_W'(num_reg[c][NLO_W-1:0]) * LH_W'(RCP_HI);
            hl_next[c] = HL_W'(num_reg[c][NUM_W-1:NLO_W]) * HL_W'(RCP_LO);
            hh_next[c] = HH_W'(num_reg[c][NUM_W-1:NLO_W]) * HH_W'(RCP_HI);

            sum[c] = SUM_W'(ll_reg[c])
                   + (SUM_W'(lh_reg[c]) << RLO_W)
                   + (SUM_W'(hl_reg[c]) << NLO_W)
                   + (SUM_W'(hh_reg[c]) << (NLO_W + RLO_W));
            quo[c] = sum[c][SUM_W-1:SHIFT];
            rgb_next[c] = (32'(quo[c]) > 32'(OUT_MAX)) ? CH_W'(OUT_MAX) : CH_W'(quo[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy3)
        begin
            num_reg <= num_next;
        end
        if (v3_reg && rdy4)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (v4_reg && rdy5)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = rgb_reg;

    `HSB_ASSERT_NEXT(a_num_hold, v3_reg && !rdy4, v3_reg && $stable(num_reg))
    `HSB_ASSERT_NEXT(a_pp_hold, v4_reg && !rdy5, v4_reg && $stable(ll_reg) && $stable(hh_reg))
    `HSB_ASSERT(a_level_cap, v5_reg |-> (32'(rgb_reg[0]) <= 32'(OUT_CAP) && 32'(rgb_reg[1]) <= 32'(OUT_CAP) && 32'(rgb_reg[2]) <= 32'(OUT_CAP)))

endmodule

>>> rtl/hsb_to_rgb_converter.sv
// Hue, saturation and brightness to red, green and blue drive levels with a
// three-sector linear blend. One item is taken every clock while the output is
// not held off. The five register stages are: clamp and sector select, blend
// weights with the brightness product, numerator product, reciprocal partial
// products, and the final sum with saturation in the output register. Each
// stage holds its item while the next one is full, so a stall on the output
// loses nothing and the input keeps filling empty stages. No state carries
// over between items and nothing has to be swept after reset.
// top level; depends on hsb2rgb_pkg, hsb2rgb_sector, hsb2rgb_blend, hsb2rgb_cdiv

module hsb_to_rgb_converter
    import hsb2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // hue[8:0], saturation[15:9], brightness[22:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // red[11:0], green[23:12], blue[35:24]
);

    logic  sect_valid;
    logic  sect_ready;
    sect_t sect_data;
    logic  wgt_valid;
    logic  wgt_ready;
    wgt_t  wgt_data;
    rgb_t  rgb;

    hsb2rgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[8:0]),
        .saturation (s_axis_tdata[15:9]),
        .brightness (s_axis_tdata[22:16]),
        .out_valid  (sect_valid),
        .out_ready  (sect_ready),
        .out_data   (sect_data)
    );

    hsb2rgb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sect_valid),
        .in_ready  (sect_ready),
        .in_data   (sect_data),
        .out_valid (wgt_valid),
        .out_ready (wgt_ready),
        .out_data  (wgt_data)
    );

    hsb2rgb_cdiv u_cdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wgt_valid),
        .in_ready  (wgt_ready),
        .in_data   (wgt_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (rgb)
    );

    assign m_axis_tdata = {4'b0000, rgb[CH_BLUE], rgb[CH_GREEN], rgb[CH_RED]};

endmodule
